// ===== rtl/rap_pkg.sv =====
// shared types, register codes and helper function of the rectangle atlas packer
package rap_pkg;

    typedef enum logic [1:0] {
        CFG_WIDTH_FLOOR = 2'd0,
        CFG_STEP_X      = 2'd1,
        CFG_STEP_Y      = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SORT_PICK,
        ST_SORT_HOLD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_PL_START,
        ST_PL_CUR,
        ST_FIT_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_WAIT_X,
        ST_SKIP_RD,
        ST_SKIP_CHK,
        ST_SKIP_END,
        ST_WAIT_Y,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    localparam logic [10:0] WIDTH_FLOOR_RST = 11'd16;
    localparam logic [6:0]  STEP_RST        = 7'd8;
    localparam logic [31:0] PLACE_Y_MAX     = 32'd65535;
    localparam logic [31:0] HEIGHT_MAX      = 32'd131071;

    // smallest power of two at or above n (1 for n of 0 or 1)
    function automatic logic [31:0] pow2_ceil(input logic [31:0] n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < 31; i++) begin
            if (n > (32'd1 << i))
                p = 32'd1 << (i + 1);
        end
        return p;
    endfunction

endpackage

// ===== rtl/rap_roundup.sv =====
// iterative round-up-to-step-multiple unit, one remainder bit per cycle
module rap_roundup #(
    parameter int VW = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [VW-1:0] value,
    input  logic [6:0]    step,
    output logic          done,
    output logic [VW-1:0] result
);

    localparam int CNTW = $clog2(VW + 1);

    logic            busy_reg, busy_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0]   shift_reg, shift_next;
    logic [VW-1:0]   orig_reg, orig_next;
    logic [6:0]      step_reg, step_next;
    logic [7:0]      rem_reg, rem_next;
    logic [7:0]      trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        orig_reg  <= orig_next;
        step_reg  <= step_next;
        rem_reg   <= rem_next;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        orig_next  = orig_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg[6:0], shift_reg[VW-1]};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNTW'(VW);
            shift_next = value;
            orig_next  = value;
            step_next  = step;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
            begin
                // restoring remainder step
                rem_next   = (trial >= {1'b0, step_reg}) ? trial - {1'b0, step_reg} : trial;
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
            end
        end
    end

    assign done   = busy_reg && (cnt_reg == '0);
    assign result = (rem_reg == '0) ? orig_reg
                                    : orig_reg + VW'({1'b0, step_reg} - rem_reg);

endmodule

// ===== rtl/rect_atlas_packer_unit.sv =====
// top level of the rectangle atlas packer: load, area sort, first-fit placement, result drain
//
// rectangles come in on the rect channel (rect_valid / rect_stall), one transfer per
// rectangle; final_rect closes the set. the closing transfer starts the run: an area
// sort by rank counting over the size memory, then first-fit placement of each
// rectangle. every tried position walks the placed rectangles; stepping past a blocking
// edge or down to the next row goes through the shared round-up unit. results then leave
// on the result channel in sorted order, one per transfer, each carrying the final atlas
// width and height; last_result marks the end of the set. rect_stall stays high from the
// closing transfer until the last result sits in the output register. a stalled receiver
// holds the output register and the drain waits. configuration is to be written through
// cfg_we / cfg_index / cfg_data only while idle; the block itself does not enforce this.
// reset clears control state, restores a width floor of 16 and steps of 8; the size
// memory needs no clearing pass, only entries below the rectangle count are read.
module rect_atlas_packer_unit #(
    parameter int MAX_RECTS = 64,
    parameter int MAX_SIDE  = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        rect_valid,
    output logic        rect_stall,
    input  logic [10:0] rect_width,
    input  logic [10:0] rect_height,
    input  logic        final_rect,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [5:0]  entry_index,
    output logic [9:0]  place_x,
    output logic [15:0] place_y,
    output logic [10:0] atlas_width,
    output logic [16:0] atlas_height,
    output logic        last_result
);

    localparam int IW = $clog2(MAX_RECTS);
    localparam int CW = IW + 1;
    localparam int SW = $clog2(MAX_SIDE) + 1;
    localparam int AW = 2 * SW;
    localparam int YW = $clog2(MAX_RECTS * MAX_SIDE) + 2;
    localparam int HW = YW + 1;

    // configuration registers
    logic [10:0] width_floor_reg;
    logic [6:0]  step_x_reg, step_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_floor_reg <= rap_pkg::WIDTH_FLOOR_RST;
            step_x_reg      <= rap_pkg::STEP_RST;
            step_y_reg      <= rap_pkg::STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (rap_pkg::cfg_idx_t'(cfg_index))
                rap_pkg::CFG_WIDTH_FLOOR: width_floor_reg <= cfg_data;
                rap_pkg::CFG_STEP_X:      step_x_reg      <= cfg_data[6:0];
                rap_pkg::CFG_STEP_Y:      step_y_reg      <= cfg_data[6:0];
                default:                  ;
            endcase
        end
    end

    // zero steps behave as one
    logic [6:0] sx, sy;
    assign sx = (step_x_reg == '0) ? 7'd1 : step_x_reg;
    assign sy = (step_y_reg == '0) ? 7'd1 : step_y_reg;

    rap_pkg::state_t state_reg, state_next;

    // control registers
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;     // sort candidate / placement index / drain index
    logic [CW-1:0] j_reg, j_next;     // inner walk index
    logic [CW-1:0] rank_reg, rank_next;
    logic          res_valid_reg, res_valid_next;
    logic [SW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;

    // datapath registers
    logic [IW-1:0] cur_id_reg, cur_id_next;
    logic [SW-1:0] cur_w_reg, cur_w_next;
    logic [SW-1:0] cur_h_reg, cur_h_next;
    logic [AW-1:0] cur_area_reg, cur_area_next;
    logic [YW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic          any_reg, any_next;
    logic [HW-1:0] minb_reg, minb_next;
    logic [5:0]    o_idx_reg, o_idx_next;
    logic [9:0]    o_x_reg, o_x_next;
    logic [15:0]   o_y_reg, o_y_next;
    logic [10:0]   o_w_reg, o_w_next;
    logic [16:0]   o_h_reg, o_h_next;
    logic          o_last_reg, o_last_next;

    // size memory, indexed by arrival order
    logic [2*SW+AW-1:0] size_mem [MAX_RECTS];
    logic [2*SW+AW-1:0] size_rd_reg;
    logic               size_we;
    logic [IW-1:0]      size_waddr, size_raddr;
    logic [2*SW+AW-1:0] size_wdata;

    // sorted slot memory {id, w, h} and placement memory {x, y}, indexed by sorted position
    logic [IW+2*SW-1:0] slot_mem [MAX_RECTS];
    logic [IW+2*SW-1:0] slot_rd_reg;
    logic [2*YW-1:0]    pos_mem [MAX_RECTS];
    logic [2*YW-1:0]    pos_rd_reg;
    logic               slot_we, pos_we;
    logic [IW-1:0]      slot_waddr, pos_waddr, slot_raddr;
    logic [IW+2*SW-1:0] slot_wdata;
    logic [2*YW-1:0]    pos_wdata;

    always_ff @(posedge clk)
    begin
        if (size_we)
            size_mem[size_waddr] <= size_wdata;
        size_rd_reg <= size_mem[size_raddr];
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        slot_rd_reg <= slot_mem[slot_raddr];
        pos_rd_reg  <= pos_mem[slot_raddr];
    end

    // shared round-up unit
    logic          ru_start, ru_done;
    logic [YW-1:0] ru_value, ru_result;
    logic [6:0]    ru_step;

    rap_roundup #(
        .VW (YW)
    ) u_roundup (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ru_start),
        .value  (ru_value),
        .step   (ru_step),
        .done   (ru_done),
        .result (ru_result)
    );

    // input side: clamp sizes, area product
    logic          in_xfer;
    logic [31:0]   w32, h32;
    logic [SW-1:0] in_w, in_h;
    logic [AW-1:0] in_area;
    logic [SW-1:0] base_width;
    logic [31:0]   minw32;

    assign in_xfer = rect_valid && !rect_stall;
    assign w32     = 32'(rect_width);
    assign h32     = 32'(rect_height);
    assign in_w    = (w32 == 32'd0) ? SW'(1)
                   : (w32 > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(w32);
    assign in_h    = (h32 == 32'd0) ? SW'(1)
                   : (h32 > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(h32);
    assign in_area = AW'(in_w) * AW'(in_h);
    assign minw32  = 32'(width_floor_reg);
    assign base_width = (count_reg == '0)
                      ? ((minw32 > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(minw32))
                      : width_reg;

    // fields of the memory read registers
    logic [SW-1:0] rd_w, rd_h;
    logic [AW-1:0] rd_area;
    logic [IW-1:0] sl_id;
    logic [SW-1:0] sl_w, sl_h;
    logic [YW-1:0] ps_x, ps_y;

    assign {rd_w, rd_h, rd_area} = size_rd_reg;
    assign {sl_id, sl_w, sl_h}   = slot_rd_reg;
    assign {ps_x, ps_y}          = pos_rd_reg;

    // overlap tests against the placed rectangle read back
    logic [HW-1:0] o_right, o_bottom, c_right, c_bottom, fit_right;
    logic          h_ovl, v_ovl, fits, beats, j_last, out_free;

    assign o_right   = HW'(ps_x) + HW'(sl_w);
    assign o_bottom  = HW'(ps_y) + HW'(sl_h);
    assign c_right   = HW'(x_reg) + HW'(cur_w_reg);
    assign c_bottom  = HW'(y_reg) + HW'(cur_h_reg);
    assign fit_right = c_right;
    assign h_ovl     = (HW'(x_reg) < o_right) && (HW'(ps_x) < c_right);
    assign v_ovl     = (HW'(ps_y) < c_bottom) && (HW'(y_reg) < o_bottom);
    assign fits      = fit_right <= HW'(width_reg);
    assign j_last    = (j_reg + 1'b1) == i_reg;
    assign out_free  = !res_valid_reg || !result_stall;
    // larger area first, equal areas keep arrival order
    assign beats     = (rd_area > cur_area_reg)
                    || ((rd_area == cur_area_reg) && (j_reg < i_reg));

    // register update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rap_pkg::ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            res_valid_reg <= 1'b0;
            width_reg     <= SW'(rap_pkg::WIDTH_FLOOR_RST);
            height_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rank_reg      <= rank_next;
            res_valid_reg <= res_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_id_reg   <= cur_id_next;
        cur_w_reg    <= cur_w_next;
        cur_h_reg    <= cur_h_next;
        cur_area_reg <= cur_area_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        any_reg      <= any_next;
        minb_reg     <= minb_next;
        o_idx_reg    <= o_idx_next;
        o_x_reg      <= o_x_next;
        o_y_reg      <= o_y_next;
        o_w_reg      <= o_w_next;
        o_h_reg      <= o_h_next;
        o_last_reg   <= o_last_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rap_pkg::ST_IDLE:
                if (in_xfer && final_rect)
                    state_next = rap_pkg::ST_SORT_PICK;
            rap_pkg::ST_SORT_PICK: state_next = rap_pkg::ST_SORT_HOLD;
            rap_pkg::ST_SORT_HOLD: state_next = rap_pkg::ST_SORT_RD;
            rap_pkg::ST_SORT_RD:   state_next = rap_pkg::ST_SORT_CMP;
            rap_pkg::ST_SORT_CMP:
                priority if ((j_reg + 1'b1) != n_reg)
                    state_next = rap_pkg::ST_SORT_RD;
                else if ((i_reg + 1'b1) != n_reg)
                    state_next = rap_pkg::ST_SORT_PICK;
                else
                    state_next = rap_pkg::ST_PL_START;
            rap_pkg::ST_PL_START:
                state_next = (i_reg == n_reg) ? rap_pkg::ST_EMIT_RD : rap_pkg::ST_PL_CUR;
            rap_pkg::ST_PL_CUR:    state_next = rap_pkg::ST_FIT_CHK;
            rap_pkg::ST_FIT_CHK:
                priority if (fits && i_reg == '0)
                    state_next = rap_pkg::ST_PLACE;
                else if (fits)
                    state_next = rap_pkg::ST_SCAN_RD;
                else if (i_reg == '0)
                    state_next = rap_pkg::ST_SKIP_END;
                else
                    state_next = rap_pkg::ST_SKIP_RD;
            rap_pkg::ST_SCAN_RD:   state_next = rap_pkg::ST_SCAN_CHK;
            rap_pkg::ST_SCAN_CHK:
                priority if (h_ovl && v_ovl)
                    state_next = rap_pkg::ST_WAIT_X;
                else if (j_last)
                    state_next = rap_pkg::ST_PLACE;
                else
                    state_next = rap_pkg::ST_SCAN_RD;
            rap_pkg::ST_WAIT_X:
                if (ru_done)
                    state_next = rap_pkg::ST_FIT_CHK;
            rap_pkg::ST_SKIP_RD:   state_next = rap_pkg::ST_SKIP_CHK;
            rap_pkg::ST_SKIP_CHK:
                state_next = j_last ? rap_pkg::ST_SKIP_END : rap_pkg::ST_SKIP_RD;
            rap_pkg::ST_SKIP_END:
                state_next = any_reg ? rap_pkg::ST_WAIT_Y : rap_pkg::ST_PLACE;
            rap_pkg::ST_WAIT_Y:
                if (ru_done)
                    state_next = rap_pkg::ST_FIT_CHK;
            rap_pkg::ST_PLACE:     state_next = rap_pkg::ST_PL_START;
            rap_pkg::ST_EMIT_RD:   state_next = rap_pkg::ST_EMIT_WR;
            rap_pkg::ST_EMIT_WR:
                if (out_free)
                    state_next = ((i_reg + 1'b1) == n_reg) ? rap_pkg::ST_IDLE
                                                           : rap_pkg::ST_EMIT_RD;
            default:               state_next = rap_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rank_next      = rank_reg;
        res_valid_next = res_valid_reg && result_stall;
        width_next     = width_reg;
        height_next    = height_reg;
        cur_id_next    = cur_id_reg;
        cur_w_next     = cur_w_reg;
        cur_h_next     = cur_h_reg;
        cur_area_next  = cur_area_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        any_next       = any_reg;
        minb_next      = minb_reg;
        o_idx_next     = o_idx_reg;
        o_x_next       = o_x_reg;
        o_y_next       = o_y_reg;
        o_w_next       = o_w_reg;
        o_h_next       = o_h_reg;
        o_last_next    = o_last_reg;
        size_we        = 1'b0;
        size_waddr     = count_reg[IW-1:0];
        size_wdata     = {in_w, in_h, in_area};
        size_raddr     = j_reg[IW-1:0];
        slot_we        = 1'b0;
        slot_waddr     = rank_reg[IW-1:0];
        slot_wdata     = {cur_id_reg, cur_w_reg, cur_h_reg};
        pos_we         = 1'b0;
        pos_waddr      = i_reg[IW-1:0];
        pos_wdata      = {x_reg, y_reg};
        slot_raddr     = j_reg[IW-1:0];
        ru_start       = 1'b0;
        ru_value       = YW'(o_right);
        ru_step        = sx;

        unique case (state_reg)
            rap_pkg::ST_IDLE:
                if (in_xfer)
                begin
                    width_next = base_width;
                    if (count_reg == '0)
                        height_next = '0;
                    if (count_reg != CW'(MAX_RECTS))
                    begin
                        size_we    = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (base_width < in_w)
                            width_next = SW'(rap_pkg::pow2_ceil(32'(in_w)));
                    end
                    if (final_rect)
                    begin
                        n_next = (count_reg != CW'(MAX_RECTS)) ? count_reg + 1'b1 : count_reg;
                        i_next = '0;
                    end
                end
            rap_pkg::ST_SORT_PICK:
                size_raddr = i_reg[IW-1:0];
            rap_pkg::ST_SORT_HOLD:
            begin
                cur_id_next   = i_reg[IW-1:0];
                cur_w_next    = rd_w;
                cur_h_next    = rd_h;
                cur_area_next = rd_area;
                j_next        = '0;
                rank_next     = '0;
            end
            rap_pkg::ST_SORT_RD:
                size_raddr = j_reg[IW-1:0];
            rap_pkg::ST_SORT_CMP:
            begin
                if ((j_reg + 1'b1) != n_reg)
                begin
                    j_next = j_reg + 1'b1;
                    if (beats)
                        rank_next = rank_reg + 1'b1;
                end
                else
                begin
                    slot_we = 1'b1;
                    if (beats)
                        slot_waddr = rank_reg[IW-1:0] + 1'b1;
                    i_next = ((i_reg + 1'b1) == n_reg) ? '0 : i_reg + 1'b1;
                end
            end
            rap_pkg::ST_PL_START:
                if (i_reg != n_reg)
                    slot_raddr = i_reg[IW-1:0];
                else
                    i_next = '0;
            rap_pkg::ST_PL_CUR:
            begin
                cur_id_next = sl_id;
                cur_w_next  = sl_w;
                cur_h_next  = sl_h;
                x_next      = '0;
                y_next      = '0;
            end
            rap_pkg::ST_FIT_CHK:
            begin
                j_next    = '0;
                any_next  = 1'b0;
                minb_next = '1;
            end
            rap_pkg::ST_SCAN_RD:
                slot_raddr = j_reg[IW-1:0];
            rap_pkg::ST_SCAN_CHK:
                if (h_ovl && v_ovl)
                begin
                    // skip past the blocking right edge to the next step multiple
                    ru_start = 1'b1;
                    ru_value = YW'(o_right);
                    ru_step  = sx;
                end
                else
                    j_next = j_reg + 1'b1;
            rap_pkg::ST_WAIT_X:
                if (ru_done)
                    x_next = ru_result;
            rap_pkg::ST_SKIP_RD:
                slot_raddr = j_reg[IW-1:0];
            rap_pkg::ST_SKIP_CHK:
            begin
                if (v_ovl)
                begin
                    any_next = 1'b1;
                    if (o_bottom < minb_reg)
                        minb_next = o_bottom;
                end
                j_next = j_reg + 1'b1;
            end
            rap_pkg::ST_SKIP_END:
                if (any_reg)
                begin
                    // next row starts at the lowest bottom edge in the band, rounded up to a step multiple
                    ru_start = 1'b1;
                    ru_value = YW'(minb_reg);
                    ru_step  = sy;
                end
                else
                    x_next = '0;
            rap_pkg::ST_WAIT_Y:
                if (ru_done)
                begin
                    y_next = ru_result;
                    x_next = '0;
                end
            rap_pkg::ST_PLACE:
            begin
                pos_we = 1'b1;
                if (height_reg < c_bottom)
                    height_next = HW'(rap_pkg::pow2_ceil(32'(c_bottom)));
                i_next = i_reg + 1'b1;
            end
            rap_pkg::ST_EMIT_RD:
                slot_raddr = i_reg[IW-1:0];
            rap_pkg::ST_EMIT_WR:
            begin
                // keep the read registers on this slot while the output is held
                slot_raddr = i_reg[IW-1:0];
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    o_idx_next     = 6'(32'(sl_id));
                    o_x_next       = 10'(32'(ps_x));
                    o_y_next       = (32'(ps_y) > rap_pkg::PLACE_Y_MAX) ? 16'hFFFF
                                                                        : 16'(32'(ps_y));
                    o_w_next       = 11'(32'(width_reg));
                    o_h_next       = (32'(height_reg) > rap_pkg::HEIGHT_MAX) ? 17'h1FFFF
                                                                           : 17'(32'(height_reg));
                    o_last_next    = (i_reg + 1'b1) == n_reg;
                    i_next         = i_reg + 1'b1;
                    if ((i_reg + 1'b1) == n_reg)
                    begin
                        count_next  = '0;
                        height_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign rect_stall   = (state_reg != rap_pkg::ST_IDLE);
    assign result_valid = res_valid_reg;
    assign entry_index  = o_idx_reg;
    assign place_x      = o_x_reg;
    assign place_y      = o_y_reg;
    assign atlas_width  = o_w_reg;
    assign atlas_height = o_h_reg;
    assign last_result  = o_last_reg;

endmodule

// ===== test/rect_atlas_packer_unit_test.sv =====
// self-checking testbench for rect_atlas_packer_unit: directed and random rectangle sets
//
// rectangle sets go in on the rect channel and the placements come back on the result
// channel. a behavioral packer in this file tracks registers and set state, and predicts
// every placement: stable area sort, then first-fit search with step skipping. results are
// compared field by field with the oldest prediction. the run walks several register
// settings, including zero and out-of-range values, and several idle and stall mixes.
module rect_atlas_packer_unit_test;

    localparam int NUM_SLOTS   = 64;
    localparam int SIDE_LIMIT  = 1024;
    localparam int STALL_LIMIT = 3000000;

    typedef struct {
        logic [5:0]  index;
        logic [9:0]  x;
        logic [15:0] y;
        logic [10:0] aw;
        logic [16:0] ah;
        logic        last;
    } placement_t;

    // directed stimulus; typed expectations only for single-rectangle sets
    typedef struct {
        int unsigned w;
        int unsigned h;
        bit          fin;
        bit          typed;
        int unsigned ex_aw;
        int unsigned ex_ah;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        rect_valid;
    logic        rect_stall;
    logic [10:0] rect_width;
    logic [10:0] rect_height;
    logic        final_rect;
    logic        result_valid;
    logic        result_stall;
    logic [5:0]  entry_index;
    logic [9:0]  place_x;
    logic [15:0] place_y;
    logic [10:0] atlas_width;
    logic [16:0] atlas_height;
    logic        last_result;

    rect_atlas_packer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rect_valid   (rect_valid),
        .rect_stall   (rect_stall),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .final_rect   (final_rect),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .entry_index  (entry_index),
        .place_x      (place_x),
        .place_y      (place_y),
        .atlas_width  (atlas_width),
        .atlas_height (atlas_height),
        .last_result  (last_result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // packer mirror: registers, open set and placement scratch
    int unsigned pk_width_floor = 16;
    int unsigned pk_step_x      = 8;
    int unsigned pk_step_y      = 8;
    int unsigned set_w [NUM_SLOTS];
    int unsigned set_h [NUM_SLOTS];
    int unsigned pos_x [NUM_SLOTS];
    int unsigned pos_y [NUM_SLOTS];
    int unsigned rank  [NUM_SLOTS];
    int unsigned set_count;
    int unsigned width_now;
    int unsigned height_now;

    placement_t  pending_placements[$];
    int          error_count;
    int          rects_sent;
    int          results_seen;
    int          sets_closed;
    int          quiet_cycles;
    int          send_idle_pct;
    int          stall_pct;

    function automatic int unsigned pow2_up(int unsigned n);
        int unsigned p;
        p = 1;
        while (p < n)
            p = p << 1;
        return p;
    endfunction

    function automatic int unsigned snap_up(int unsigned v, int unsigned s);
        return ((v + s - 1) / s) * s;
    endfunction

    function automatic int unsigned clamp_side(int unsigned v);
        if (v < 1)
            return 1;
        if (v > SIDE_LIMIT)
            return SIDE_LIMIT;
        return v;
    endfunction

    // stable insertion sort, largest area first
    function automatic void sort_set();
        int unsigned cur;
        int unsigned area;
        int          j;
        for (int i = 0; i < set_count; i++)
            rank[i] = i;
        for (int i = 1; i < set_count; i++) begin
            cur = rank[i];
            area = set_w[cur] * set_h[cur];
            j = i;
            while (j > 0 && set_w[rank[j-1]] * set_h[rank[j-1]] < area) begin
                rank[j] = rank[j-1];
                j--;
            end
            rank[j] = cur;
        end
    endfunction

    // first-fit search for rank k against ranks below it
    function automatic void place_rank(int k, int unsigned sx, int unsigned sy);
        int unsigned id;
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned o;
        int unsigned low_edge;
        int          hit;
        bit          fit;
        bit          any_row;
        id = rank[k];
        w = set_w[id];
        h = set_h[id];
        x = 0;
        y = 0;
        forever
        begin
            fit = 0;
            x = 0;
            while (x + w <= width_now) begin
                hit = k;
                for (int j = 0; j < k; j++) begin
                    o = rank[j];
                    if (x < pos_x[o] + set_w[o] && pos_x[o] < x + w &&
                        y < pos_y[o] + set_h[o] && pos_y[o] < y + h) begin
                        hit = j;
                        break;
                    end
                end
                if (hit == k) begin
                    fit = 1;
                    break;
                end
                x = snap_up(pos_x[rank[hit]] + set_w[rank[hit]], sx);
            end
            if (fit)
                break;
            // drop to the first row past the nearest bottom edge in the band
            any_row = 0;
            low_edge = 32'hFFFF_FFFF;
            for (int j = 0; j < k; j++) begin
                o = rank[j];
                if (pos_y[o] < y + h && y < pos_y[o] + set_h[o]) begin
                    any_row = 1;
                    if (pos_y[o] + set_h[o] < low_edge)
                        low_edge = pos_y[o] + set_h[o];
                end
            end
            if (!any_row) begin
                x = 0;
                break;
            end
            y = snap_up(low_edge, sy);
        end
        pos_x[id] = x;
        pos_y[id] = y;
        if (height_now < y + h)
            height_now = pow2_up(y + h);
    endfunction

    // accepts one rectangle; a closing rectangle queues the whole set
    function automatic void predict_rect(int unsigned w_in, int unsigned h_in, bit fin);
        int unsigned w;
        int unsigned h;
        int unsigned sx;
        int unsigned sy;
        placement_t  p;
        w = clamp_side(w_in);
        h = clamp_side(h_in);
        if (set_count == 0) begin
            width_now = pk_width_floor > SIDE_LIMIT ? SIDE_LIMIT : pk_width_floor;
            height_now = 0;
        end
        if (set_count < NUM_SLOTS) begin
            set_w[set_count] = w;
            set_h[set_count] = h;
            set_count++;
            if (width_now < w)
                width_now = pow2_up(w);
        end
        if (!fin)
            return;
        sx = pk_step_x == 0 ? 1 : pk_step_x;
        sy = pk_step_y == 0 ? 1 : pk_step_y;
        sort_set();
        for (int k = 0; k < set_count; k++)
            place_rank(k, sx, sy);
        for (int k = 0; k < set_count; k++) begin
            p.index = 6'(rank[k]);
            p.x = 10'(pos_x[rank[k]]);
            p.y = pos_y[rank[k]] > 65535 ? 16'hFFFF : 16'(pos_y[rank[k]]);
            p.aw = 11'(width_now);
            p.ah = height_now > 131071 ? 17'h1FFFF : 17'(height_now);
            p.last = (k + 1 == set_count);
            pending_placements = {pending_placements, p};
        end
        set_count = 0;
        height_now = 0;
        sets_closed++;
    endfunction

    // result side: random stall, check every transfer against the oldest prediction
    always @(posedge clk)
    begin
        placement_t p;
        if (rst_n && result_valid && !result_stall) begin
            results_seen++;
            if (pending_placements.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end
            else begin
                p = pending_placements.pop_front();
                if (entry_index !== p.index) begin
                    $error("entry_index expected %0d got %0d", p.index, entry_index);
                    error_count++;
                end
                if (place_x !== p.x) begin
                    $error("place_x expected %0d got %0d", p.x, place_x);
                    error_count++;
                end
                if (place_y !== p.y) begin
                    $error("place_y expected %0d got %0d", p.y, place_y);
                    error_count++;
                end
                if (atlas_width !== p.aw) begin
                    $error("atlas_width expected %0d got %0d", p.aw, atlas_width);
                    error_count++;
                end
                if (atlas_height !== p.ah) begin
                    $error("atlas_height expected %0d got %0d", p.ah, atlas_height);
                    error_count++;
                end
                if (last_result !== p.last) begin
                    $error("last_result expected %0d got %0d", p.last, last_result);
                    error_count++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((rect_valid && !rect_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(rap_pkg::cfg_idx_t idx, logic [10:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            rap_pkg::CFG_WIDTH_FLOOR: pk_width_floor = 32'(value);
            rap_pkg::CFG_STEP_X:      pk_step_x = 32'(value[6:0]);
            rap_pkg::CFG_STEP_Y:      pk_step_y = 32'(value[6:0]);
            default:                  ;
        endcase
    endtask

    task automatic wait_drained();
        rect_valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // registers change only once every result of the previous set has drained
    task automatic set_regs(logic [10:0] mw, logic [10:0] sx, logic [10:0] sy);
        wait_drained();
        write_reg(rap_pkg::CFG_WIDTH_FLOOR, mw);
        write_reg(rap_pkg::CFG_STEP_X, sx);
        write_reg(rap_pkg::CFG_STEP_Y, sy);
        cfg_we <= 1'b0;
    endtask

    // one rect transfer with random idle ahead of it, predicted on acceptance
    task automatic send_rect(int unsigned w, int unsigned h, bit fin);
        while ($urandom_range(99) < send_idle_pct) begin
            rect_valid <= 1'b0;
            @(posedge clk);
        end
        rect_valid <= 1'b1;
        rect_width <= 11'(w);
        rect_height <= 11'(h);
        final_rect <= fin;
        do
            @(posedge clk);
        while (rect_stall);
        rects_sent++;
        predict_rect(w, h, fin);
    endtask

    function automatic int unsigned random_side();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(64, 1);
        if (pick < 92)
            return $urandom_range(SIDE_LIMIT, 1);
        if (pick < 96)
            return 0;
        return $urandom_range(2047, 1025);
    endfunction

    task automatic random_set(int max_len);
        int len;
        len = $urandom_range(max_len, 1);
        for (int i = 0; i < len; i++)
            send_rect(random_side(), random_side(), i == len - 1);
    endtask

    directed_row_t directed_rows[] = '{
        '{1, 1, 1, 1, 16, 1},
        '{2047, 2047, 1, 1, 1024, 1024},
        '{0, 0, 1, 1, 16, 1},
        '{1024, 1, 1, 1, 1024, 1},
        '{17, 1, 1, 1, 32, 1},
        // equal areas keep arrival order
        '{8, 4, 0, 0, 0, 0},
        '{4, 8, 0, 0, 0, 0},
        '{2, 16, 1, 0, 0, 0},
        // edges touching, second row after wrap
        '{16, 8, 0, 0, 0, 0},
        '{8, 8, 0, 0, 0, 0},
        '{8, 8, 1, 0, 0, 0},
        // widening mid-set to a power of two
        '{5, 5, 0, 0, 0, 0},
        '{300, 3, 0, 0, 0, 0},
        '{5, 5, 1, 0, 0, 0},
        // alternating bit patterns, clamped and not
        '{1365, 682, 0, 0, 0, 0},
        '{682, 1365, 0, 0, 0, 0},
        '{2047, 1, 0, 0, 0, 0},
        '{1, 2047, 1, 0, 0, 0}
    };

    initial
    begin
        placement_t typed_p;
        error_count = 0;
        rects_sent = 0;
        results_seen = 0;
        sets_closed = 0;
        quiet_cycles = 0;
        set_count = 0;
        width_now = 16;
        height_now = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rap_pkg::CFG_WIDTH_FLOOR;
        cfg_data = '0;
        rect_valid = 1'b0;
        rect_width = 11'd1;
        rect_height = 11'd1;
        final_rect = 1'b0;
        result_stall = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset register values
        foreach (directed_rows[i]) begin
            send_rect(directed_rows[i].w, directed_rows[i].h, directed_rows[i].fin);
            if (directed_rows[i].typed) begin
                // single-rectangle set: result can be written down directly
                typed_p = '{6'd0, 10'd0, 16'd0, directed_rows[i].ex_aw[10:0],
                            directed_rows[i].ex_ah[16:0], 1'b1};
                pending_placements[pending_placements.size() - 1] = typed_p;
            end
        end

        // register extremes, the unused index, and a few odd values
        set_regs(11'd0, 11'd1, 11'd1);
        write_reg(rap_pkg::CFG_UNUSED, 11'h7FF);
        cfg_we <= 1'b0;
        for (int i = 0; i < 6; i++)
            random_set(5);
        set_regs(11'd1024, 11'd64, 11'd64);
        for (int i = 0; i < 6; i++)
            random_set(5);
        set_regs(11'h7FF, 11'd0, 11'd0);
        for (int i = 0; i < 6; i++)
            random_set(5);

        // store overflow: 66 rectangles, the last two dropped, the final one closing the set
        set_regs(11'd1024, 11'd16, 11'd16);
        for (int i = 0; i < 66; i++)
            send_rect(16, 16, i == 65);

        // random phases, cycling through the idle and stall mixes
        for (int phase = 0; rects_sent < 420; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 63; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            set_regs(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                     11'($urandom_range(2047)));
            for (int i = 0; i < 5; i++) begin
                // sender holds back until the block has drained completely
                if (phase == 2 && i == 2)
                    wait_drained();
                random_set($urandom_range(9) == 0 ? 12 : 6);
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);
        $display("covered %0d rectangles in %0d sets, %0d placements checked",
                 rects_sent, sets_closed, results_seen);
        $display("register extremes, store overflow, clamped sizes and mixed stalls included");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rap_pkg.sv
rtl/rap_roundup.sv
rtl/rect_atlas_packer_unit.sv
test/rect_atlas_packer_unit_test.sv
